FILE: sv/dcs_pkg.sv
// dcs_pkg: shared types and constants for the divisor count sum unit
// used by divisor_count_sum_unit and its bench; no dependencies
package dcs_pkg;

    // default number of limit bits the block uses
    localparam int LIMIT_BITS_DEF = 32;
    // width of the result field, the accumulator wraps at this width
    localparam int TOTAL_BITS     = 37;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_QUO,
        S_END,
        S_FINISH
    } t_state;

endpackage

FILE: sv/dcs_div.sv
// dcs_div: restoring unsigned divider, one quotient bit per cycle
// used by divisor_count_sum_unit; depends on nothing but its parameter
module dcs_div #(
    parameter int W = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    output logic         o_done,
    output logic [W-1:0] o_quot
);

    localparam int CW = $clog2(W);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_dvd;
    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_dsr;
    logic [W:0]    trial;
    logic [W:0]    diff;
    logic          fits;

    // one trial subtract per cycle
    always_comb begin
        trial = {r_rem, r_dvd[W-1]};
        diff  = trial - {1'b0, r_dsr};
        fits  = !diff[W];
    end

    // control: step counter and done strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: dividend register collects the quotient bits from the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[W-2:0], fits};
            r_rem <= fits ? diff[W-1:0] : trial[W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_dvd;

endmodule

FILE: sv/divisor_count_sum_unit.sv
// divisor_count_sum_unit: sum of floor(n / i) for i = 1..n over runs of equal quotient
// depends on dcs_pkg and dcs_div
//
//  channel | ports                      | handshake
//  --------+----------------------------+------------------------------------
//  input   | i_limit                    | taken when i_start high, o_busy low
//  result  | o_total                    | shown for one cycle with o_valid
//
// About 2*sqrt(n) runs of equal quotient per item. Each run takes two passes
// of the shared bit-serial divider plus a pass through S_CHECK. The run
// length times quotient product is done by a shift-add unit that overlaps
// the next run's divisions. Reset is synchronous and idles the sequencer;
// o_busy stays high from the accepting edge until the cycle of the o_valid
// strobe. The receiver cannot stall.
module divisor_count_sum_unit
    import dcs_pkg::*;
#(
    parameter int LIMIT_BITS = LIMIT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [LIMIT_BITS-1:0] i_limit,
    output logic                  o_busy,
    output logic                  o_valid,
    output logic [TOTAL_BITS-1:0] o_total
);

    localparam int W = LIMIT_BITS;

    t_state                r_state;
    t_state                n_state;
    logic [W-1:0]          r_n;
    logic [W:0]            r_lo;
    logic [W-1:0]          r_quo;
    logic [TOTAL_BITS-1:0] r_acc;
    logic [TOTAL_BITS-1:0] r_mcand;
    logic [W-1:0]          r_mplier;
    logic                  r_valid;
    logic [TOTAL_BITS-1:0] r_total;

    logic                  div_start;
    logic [W-1:0]          div_divisor;
    logic                  div_done;
    logic [W-1:0]          div_quot;
    logic                  mul_idle;
    logic [W-1:0]          run_len;
    logic [TOTAL_BITS+W-1:0] quo_ext;

    dcs_div #(.W(W)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_n),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    assign mul_idle = (r_mplier == '0);
    // run end comes from the divider in S_END; hi >= lo so the length fits
    assign run_len  = div_quot - r_lo[W-1:0] + 1'b1;
    assign quo_ext  = {{TOTAL_BITS{1'b0}}, r_quo};

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and divider requests
    always_comb begin
        n_state     = r_state;
        div_start   = 1'b0;
        div_divisor = r_lo[W-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (r_lo > {1'b0, r_n}) begin
                    n_state = S_FINISH;
                end else begin
                    div_start = 1'b1;
                    n_state   = S_QUO;
                end
            end
            S_QUO: begin
                // quotient known, ask for the last index sharing it
                if (div_done) begin
                    div_start   = 1'b1;
                    div_divisor = div_quot;
                    n_state     = S_END;
                end
            end
            S_END: begin
                if (div_done) begin
                    n_state = S_CHECK;
                end
            end
            S_FINISH: begin
                if (mul_idle) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // run bookkeeping
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_n  <= i_limit;
            r_lo <= (W+1)'(1);
        end else if (r_state == S_QUO && div_done) begin
            r_quo <= div_quot;
        end else if (r_state == S_END && div_done) begin
            r_lo <= {1'b0, div_quot} + 1'b1;
        end
    end

    // shift-add multiply accumulate of run length times quotient
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mplier <= '0;
        end else if (r_state == S_IDLE && i_start) begin
            r_mplier <= '0;
            r_acc    <= '0;
        end else if (r_state == S_END && div_done) begin
            r_mplier <= run_len;
            r_mcand  <= quo_ext[TOTAL_BITS-1:0];
        end else if (!mul_idle) begin
            if (r_mplier[0]) begin
                r_acc <= r_acc + r_mcand;
            end
            r_mcand  <= {r_mcand[TOTAL_BITS-2:0], 1'b0};
            r_mplier <= {1'b0, r_mplier[W-1:1]};
        end
    end

    // result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= (r_state == S_FINISH) && mul_idle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FINISH && mul_idle) begin
            r_total <= r_acc;
        end
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_total = r_total;

endmodule

FILE: tb/tb_top.sv
// tb_top: self-checking bench for divisor_count_sum_unit, a directed table then random limits
// depends on dcs_pkg and divisor_count_sum_unit; totals checked against typed-in or predictor values
`timescale 1ns / 1ps

module tb_top;
    import dcs_pkg::*;

    localparam int          LIM_W      = LIMIT_BITS_DEF;
    localparam int          RAND_ITEMS = 100;
    localparam longint      MAX_CYCLES = 100_000_000;
    localparam int          TAIL_WAIT  = 200;

    // one row of the directed table; known rows carry a typed-in total
    typedef struct packed {
        logic [LIM_W-1:0]      limit;
        logic                  known;
        logic [TOTAL_BITS-1:0] total;
    } t_row;

    // one outstanding total, with the limit that caused it
    typedef struct packed {
        logic [LIM_W-1:0]      limit;
        logic [TOTAL_BITS-1:0] total;
    } t_pending;

    localparam int N_ROWS = 16;
    localparam t_row DIRECTED [N_ROWS] = '{
        '{32'd0,          1'b1, 37'd0},
        '{32'd1,          1'b1, 37'd1},
        '{32'd2,          1'b1, 37'd3},
        '{32'd3,          1'b1, 37'd5},
        '{32'd4,          1'b1, 37'd8},
        '{32'd5,          1'b1, 37'd10},
        '{32'd6,          1'b1, 37'd14},
        '{32'd12,         1'b1, 37'd35},
        '{32'd0,          1'b1, 37'd0},
        '{32'd99,         1'b0, 37'd0},
        '{32'd100,        1'b0, 37'd0},
        '{32'd65535,      1'b0, 37'd0},
        '{32'd65536,      1'b0, 37'd0},
        '{32'h0010_0000,  1'b0, 37'd0},
        '{32'hFFFF_FFFF,  1'b0, 37'd0},
        '{32'd7,          1'b1, 37'd16}
    };

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_start;
    logic [LIM_W-1:0]      i_limit;
    logic                  o_busy;
    logic                  o_valid;
    logic [TOTAL_BITS-1:0] o_total;

    // expected totals, oldest first
    t_pending              totals_due[$];
    t_pending              due_item;
    int unsigned           errors;
    longint                cycles;
    // typed-in total for the item being driven, if any
    logic                  row_known;
    logic [TOTAL_BITS-1:0] row_total;
    // sender idling on or off for a stretch of items
    bit                    sender_idles;

    divisor_count_sum_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_limit (i_limit),
        .o_busy  (o_busy),
        .o_valid (o_valid),
        .o_total (o_total)
    );

    // clock, 10 ns period
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // sum of floor(n / i) over runs of equal quotient, wide enough not to overflow
    function automatic logic [TOTAL_BITS-1:0] divisor_total(input logic [LIM_W-1:0] n);
        logic [63:0] lim;
        logic [63:0] acc;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] quo;
        lim = 64'(n);
        acc = 64'd0;
        lo  = 64'd1;
        while (lo <= lim) begin
            quo = lim / lo;
            hi  = lim / quo;
            if (hi > lim) begin
                hi = lim;
            end
            acc = acc + (hi - lo + 64'd1) * quo;
            lo  = hi + 64'd1;
        end
        return acc[TOTAL_BITS-1:0];
    endfunction

    // mostly small limits, a few below 2^20 to keep the run short
    function automatic logic [LIM_W-1:0] draw_limit();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            return LIM_W'($urandom_range(0, 255));
        end else if (pick < 85) begin
            return LIM_W'($urandom_range(256, 65535));
        end
        return LIM_W'($urandom_range(65536, (1 << 20) - 1));
    endfunction

    // cycle counter and timeout
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLES) begin
            $display("%0t: timeout after %0d cycles", $time, cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // result check first, then record the item accepted at this edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid) begin
                if (totals_due.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected total, expected none, got %0d", $time, o_total);
                end else begin
                    due_item = totals_due.pop_front();
                    if (o_total !== due_item.total) begin
                        errors++;
                        $display("%0t: total for limit %0d: expected %0d, got %0d",
                                 $time, due_item.limit, due_item.total, o_total);
                    end
                end
            end
            if (i_start && !o_busy) begin
                totals_due.push_back('{i_limit,
                                       row_known ? row_total : divisor_total(i_limit)});
            end
        end
    end

    // drive one item from a falling edge, return at the falling edge after acceptance
    task automatic send_limit(input logic [LIM_W-1:0] n, input logic known,
                              input logic [TOTAL_BITS-1:0] total);
        int unsigned gap;
        bit          after_busy;
        gap        = sender_idles ? $urandom_range(0, 6) : 0;
        after_busy = sender_idles && ($urandom_range(0, 1) == 1);
        if (gap != 0 || after_busy) begin
            i_start <= 1'b0;
            if (after_busy) begin
                do @(posedge i_clk); while (o_busy);
                @(negedge i_clk);
            end
            repeat (gap) @(negedge i_clk);
        end
        row_known = known;
        row_total = total;
        i_start <= 1'b1;
        i_limit <= n;
        do @(posedge i_clk); while (o_busy);
        @(negedge i_clk);
    endtask

    // hold the sender off until every total has come back
    task automatic drain_totals();
        i_start <= 1'b0;
        do @(posedge i_clk); while (totals_due.size() != 0);
        @(negedge i_clk);
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_start      = 1'b0;
        i_limit      = '0;
        row_known    = 1'b0;
        row_total    = '0;
        errors       = 0;
        cycles       = 0;
        sender_idles = 1'b1;

        // synchronous reset, released at a falling edge
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed table
        foreach (DIRECTED[k]) begin
            send_limit(DIRECTED[k].limit, DIRECTED[k].known, DIRECTED[k].total);
        end
        drain_totals();

        // random limits, idling switched on and off in stretches of ten items
        for (int k = 0; k < RAND_ITEMS; k++) begin
            if (k % 10 == 0) begin
                sender_idles = $urandom_range(0, 2) != 0;
            end
            send_limit(draw_limit(), 1'b0, '0);
        end

        // wait for the last total, then a quiet tail
        drain_totals();
        repeat (TAIL_WAIT) @(posedge i_clk);

        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
sv/dcs_pkg.sv
sv/dcs_div.sv
sv/divisor_count_sum_unit.sv
tb/tb_top.sv
